[rtl/core/utoa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utoa_pkg: shared constants and helpers for the binary to ASCII converter
// Sizes of the digit register and counters, and the digit to ASCII mapping.
// ----------------------------------------------------------------------------
package utoa_pkg;

  // Number of value bits that take part in the conversion (8 to 64)
  localparam int VALUE_BITS = 32;
  // Width of the value field on the input channel
  localparam int IN_VALUE_W = 32;
  localparam int CHAR_W     = 7;
  localparam int KIND_W     = 2;

  // Decimal digits of the largest value: floor(bits * log10(2)) + 1
  localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DIGIT_REG_W = NUM_DIGITS * 4;
  localparam int REM_W       = $clog2(NUM_DIGITS + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_BITS);

  // Mode codes on the kind field
  localparam logic [KIND_W-1:0] KIND_DEC = 2'd0;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'd97;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'd65;
  localparam logic [3:0]        DIGIT_TEN  = 4'd10;

  // Map one digit (0 to 15) onto its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] digit,
                                                    input logic       upper);
    logic [CHAR_W-1:0] letter_base;
    letter_base = upper ? CHAR_UPPER : CHAR_LOWER;
    if (digit < DIGIT_TEN) begin
      return CHAR_ZERO + CHAR_W'(digit);
    end else begin
      return letter_base + CHAR_W'(digit - DIGIT_TEN);
    end
  endfunction

endpackage

[rtl/core/utoa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utoa_if: item channels of the binary to ASCII converter
// Input channel carries value and mode; output channel carries characters.
// ----------------------------------------------------------------------------
interface utoa_in_if import utoa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [IN_VALUE_W-1:0] value;
  logic [KIND_W-1:0]     kind;

  modport source (output valid, output value, output kind, input ready);
  modport sink   (input valid, input value, input kind, output ready);
endinterface

interface utoa_out_if import utoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

[rtl/core/unsigned_to_ascii_digits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits: unsigned value to ASCII decimal or hex digits
// Bit-serial double dabble for decimal, direct nibble load for hex, then
// leading zero removal and one character per cycle unless stalled, MSB first.
// ----------------------------------------------------------------------------
// One item at a time. A decimal item runs through the bit-serial double
// dabble loop, which shifts one value bit per cycle into the BCD digit
// register; a hex item loads its nibbles directly. Then leading zero
// digits are dropped one by one, and the characters are emitted while the
// sink takes them. The last character of an item carries last; zero gives
// the single character '0'. A new item is taken as soon as the previous
// one's last character sits in the output register.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits import utoa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  utoa_in_if.sink    in_i,
  utoa_out_if.source out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [VALUE_BITS-1:0]  src_q;
  logic [DIGIT_REG_W-1:0] digits_q;
  logic [BIT_CNT_W-1:0]   bit_cnt_q;
  logic [REM_W-1:0]       rem_q;
  logic                   upper_q;
  logic                   out_valid_q;
  logic [CHAR_W-1:0]      char_q;
  logic                   last_q;

  logic [VALUE_BITS-1:0]  masked;
  logic [DIGIT_REG_W-1:0] digits_adj;
  logic [3:0]             top_digit;
  logic                   emit_fire;

  // Keep the low VALUE_BITS bits of the input value
  assign masked = VALUE_BITS'({{VALUE_BITS{1'b0}}, in_i.value});

  assign top_digit = digits_q[DIGIT_REG_W-1 -: 4];

  // Emit a character whenever the output register frees up
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  // Add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits_q[i*4 +: 4] >= 4'd5) begin
        digits_adj[i*4 +: 4] = digits_q[i*4 +: 4] + 4'd3;
      end else begin
        digits_adj[i*4 +: 4] = digits_q[i*4 +: 4];
      end
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last      = last_q;

  // Sequence conversion, leading zero removal and character output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_q       <= '0;
      digits_q    <= '0;
      bit_cnt_q   <= '0;
      rem_q       <= '0;
      upper_q     <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      // Load the output item on an emit, drop it once taken
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            upper_q <= in_i.kind[1];
            rem_q   <= REM_W'(NUM_DIGITS);
            if (in_i.kind == KIND_DEC) begin
              src_q     <= masked;
              digits_q  <= '0;
              bit_cnt_q <= BIT_CNT_W'(VALUE_BITS - 1);
              state_q   <= ST_CONV;
            end else begin
              digits_q <= DIGIT_REG_W'(masked);
              state_q  <= ST_SKIP;
            end
          end
        end

        ST_CONV: begin
          // Shift one value bit into the adjusted BCD register
          digits_q  <= {digits_adj[DIGIT_REG_W-2:0], src_q[VALUE_BITS-1]};
          src_q     <= {src_q[VALUE_BITS-2:0], 1'b0};
          bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
          if (bit_cnt_q == '0) begin
            state_q <= ST_SKIP;
          end
        end

        ST_SKIP: begin
          // Drop leading zero digits, keep at least one
          if (top_digit == 4'd0 && rem_q > REM_W'(1)) begin
            digits_q <= {digits_q[DIGIT_REG_W-5:0], 4'd0};
            rem_q    <= rem_q - REM_W'(1);
          end else begin
            state_q <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          // Advance one character whenever the output register frees up
          if (emit_fire) begin
            char_q      <= digit_char(top_digit, upper_q);
            last_q      <= (rem_q == REM_W'(1));
            digits_q    <= {digits_q[DIGIT_REG_W-5:0], 4'd0};
            rem_q       <= rem_q - REM_W'(1);
            if (rem_q == REM_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The digit count never runs out while characters are still due
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT || state_q == ST_SKIP) |-> rem_q != '0)
    else $error("digit count empty during emit");

  // An accepted item blocks the input until its last character is in the output register
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready right after accepting an item");

  // Every emitted character is a digit or a hex letter
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.char_code >= CHAR_ZERO && out_o.char_code <= 7'd102))
    else $error("character code out of range");

  // A stalled output item holds its character and last flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=>
    (out_o.valid && $stable(out_o.char_code) && $stable(out_o.last)))
    else $error("output item changed while stalled");
`endif

endmodule

[sim/unsigned_to_ascii_digits_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits_tb: self-checking bench for the digit converter
// Feeds numbers in decimal, lower-case hex and upper-case hex (mode three
// too), spells each one out in the bench and compares every character and
// last flag as it leaves the block. Both channels idle at random.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits_tb import utoa_pkg::*; ();

  localparam int CLK_HALF    = 4;
  localparam int IDLE_PCT    = 28;
  localparam int REPORT_MAX  = 10;
  localparam int RANDOM_NUMS = 350;
  localparam int TAIL_CYCLES = 60;
  localparam int CALM_FIRST  = 6000;
  localparam int CALM_LAST   = 9000;
  localparam int WATCHDOG_NS = 4_000_000;

  // Mode codes besides decimal, which comes from the package
  localparam logic [KIND_W-1:0] KIND_HEX_LOWER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HEX_UPPER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HEX_ALT   = 2'd3;

  localparam logic [63:0] VALUE_MASK =
    (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } digit_char_t;

  typedef struct {
    logic [IN_VALUE_W-1:0] value;
    logic [KIND_W-1:0]     kind;
    bit                    drain_first;
  } number_t;

  logic clk_i;
  logic rst_ni;
  int   cycle_count;
  logic calm;

  utoa_in_if  in_if ();
  utoa_out_if out_if ();

  number_t     pending_numbers[$];
  digit_char_t expected_chars[$];

  int numbers_total;
  int numbers_taken;
  int decimal_taken;
  int hex_taken;
  int zero_taken;
  int chars_predicted;
  int chars_seen;
  int lasts_seen;
  int failures;

  unsigned_to_ascii_digits u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Free-running clock
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Cycle count; both sides stop idling inside the calm window
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end
  assign calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

  // Spell a number out into the expected characters, most significant first
  function automatic void spell_number(input logic [IN_VALUE_W-1:0] value,
                                       input logic [KIND_W-1:0]     kind);
    logic [63:0]  rest;
    logic [63:0]  radix;
    logic [3:0]   digit;
    logic         upper;
    digit_char_t  one;
    digit_char_t  digits[$];
    rest  = 64'(value) & VALUE_MASK;
    radix = (kind == KIND_DEC) ? 64'd10 : 64'd16;
    upper = kind[1];
    do begin
      digit = 4'(rest % radix);
      if (digit < 4'd10) begin
        one.code = CHAR_ZERO + CHAR_W'(digit);
      end else begin
        one.code = (upper ? CHAR_UPPER : CHAR_LOWER) + CHAR_W'(digit - 4'd10);
      end
      one.last = 1'b0;
      digits.push_front(one);
      rest = rest / radix;
    end while (rest != 64'd0);
    digits[digits.size() - 1].last = 1'b1;
    foreach (digits[i]) begin
      expected_chars.push_back(digits[i]);
    end
    chars_predicted += digits.size();
  endfunction

  function automatic void note_failure(input string what);
    failures++;
    if (failures <= REPORT_MAX) begin
      $display("[%0t] ERROR: %s", $time, what);
    end
  endfunction

  function automatic void add_number(input logic [IN_VALUE_W-1:0] value,
                                     input logic [KIND_W-1:0]     kind,
                                     input bit                    drain_first);
    number_t n;
    n.value       = value;
    n.kind        = kind;
    n.drain_first = drain_first;
    pending_numbers.push_back(n);
  endfunction

  // Pick a random number shaped to hit every digit count and the carries
  function automatic logic [IN_VALUE_W-1:0] random_value();
    logic [63:0] power;
    int          steps;
    power = 64'd1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom >> $urandom_range(0, 31);
      7:          return $urandom_range(0, 20);
      8: begin
        steps = $urandom_range(0, 9);
        repeat (steps) power = power * 64'd10;
        return IN_VALUE_W'(power - 64'($urandom_range(0, 1)));
      end
      default: begin
        steps = $urandom_range(0, 7);
        power = power << (4 * steps);
        return IN_VALUE_W'(power - 64'($urandom_range(0, 1)));
      end
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] random_kind();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return KIND_DEC;
      5, 6:          return KIND_HEX_LOWER;
      7, 8:          return KIND_HEX_UPPER;
      default:       return KIND_HEX_ALT;
    endcase
  endfunction

  // Driver: hold an item until taken, then present the next one or idle
  always @(posedge clk_i) begin
    number_t next;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        spell_number(in_if.value, in_if.kind);
        numbers_taken++;
        if (in_if.kind == KIND_DEC) decimal_taken++;
        else hex_taken++;
        if ((64'(in_if.value) & VALUE_MASK) == 64'd0) zero_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_numbers.size() > 0 &&
            !(pending_numbers[0].drain_first && chars_seen != chars_predicted) &&
            (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next = pending_numbers.pop_front();
          in_if.valid <= 1'b1;
          in_if.value <= next.value;
          in_if.kind  <= next.kind;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each character against the oldest expectation
  always @(posedge clk_i) begin
    digit_char_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        chars_seen <= chars_seen + 1;
        if (out_if.last) lasts_seen++;
        if (expected_chars.size() == 0) begin
          note_failure($sformatf("unexpected char 0x%02h last %0b",
                                 out_if.char_code, out_if.last));
        end else begin
          want = expected_chars.pop_front();
          if (out_if.char_code !== want.code || out_if.last !== want.last) begin
            note_failure($sformatf("char 0x%02h last %0b, expected 0x%02h last %0b",
                                   out_if.char_code, out_if.last,
                                   want.code, want.last));
          end
        end
      end
      out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    rst_ni          = 1'b0;
    cycle_count     = 0;
    in_if.valid     = 1'b0;
    in_if.value     = '0;
    in_if.kind      = KIND_DEC;
    out_if.ready    = 1'b0;
    numbers_taken   = 0;
    decimal_taken   = 0;
    hex_taken       = 0;
    zero_taken      = 0;
    chars_predicted = 0;
    chars_seen      = 0;
    lasts_seen      = 0;
    failures        = 0;

    // Zero and all-ones in every mode, mode three included
    add_number(32'd0, KIND_DEC, 1'b0);
    add_number(32'd0, KIND_HEX_LOWER, 1'b0);
    add_number(32'd0, KIND_HEX_UPPER, 1'b0);
    add_number(32'd0, KIND_HEX_ALT, 1'b0);
    add_number(32'hFFFF_FFFF, KIND_DEC, 1'b0);
    add_number(32'hFFFF_FFFF, KIND_HEX_LOWER, 1'b0);
    add_number(32'hFFFF_FFFF, KIND_HEX_UPPER, 1'b0);
    add_number(32'hFFFF_FFFF, KIND_HEX_ALT, 1'b0);
    // Single digits and the step to two digits
    add_number(32'd1, KIND_DEC, 1'b0);
    add_number(32'd9, KIND_DEC, 1'b0);
    add_number(32'd10, KIND_DEC, 1'b0);
    add_number(32'd15, KIND_HEX_LOWER, 1'b0);
    add_number(32'd16, KIND_HEX_UPPER, 1'b0);
    // Letters in both cases and ten-digit decimal boundaries
    add_number(32'hABCD_EF90, KIND_HEX_LOWER, 1'b0);
    add_number(32'hABCD_EF90, KIND_HEX_UPPER, 1'b0);
    add_number(32'hABCD_EF90, KIND_HEX_ALT, 1'b0);
    add_number(32'd999_999_999, KIND_DEC, 1'b0);
    add_number(32'd1_000_000_000, KIND_DEC, 1'b0);
    add_number(32'h8000_0000, KIND_HEX_LOWER, 1'b0);
    add_number(32'h7FFF_FFFF, KIND_DEC, 1'b0);
    add_number(32'h0123_4567, KIND_HEX_UPPER, 1'b0);

    // Random numbers; pause for a full drain three times along the way
    for (int i = 0; i < RANDOM_NUMS; i++) begin
      add_number(random_value(), random_kind(), (i == 0) || (i == 60) || (i == 220));
    end
    numbers_total = pending_numbers.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (numbers_taken < numbers_total) @(posedge clk_i);
    while (chars_seen != chars_predicted) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_chars.size() != 0) begin
      note_failure($sformatf("%0d expected chars never arrived", expected_chars.size()));
    end
    $display("Converted %0d numbers (%0d decimal, %0d hex, %0d zero) into %0d chars,",
             numbers_taken, decimal_taken, hex_taken, zero_taken, chars_seen);
    $display("with %0d last flags and %0d failures seen.", lasts_seen, failures);
    if (failures == 0) begin
      $display("unsigned_to_ascii_digits regression: pass");
    end else begin
      $display("unsigned_to_ascii_digits regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #(WATCHDOG_NS);
    $display("unsigned_to_ascii_digits regression: fail");
    $finish;
  end

endmodule

[files.f]
rtl/core/utoa_pkg.sv
rtl/core/utoa_if.sv
rtl/core/unsigned_to_ascii_digits.sv
sim/unsigned_to_ascii_digits_tb.sv
